FILE: rtl/core/line_pixel_rasterizer_macros.svh
// Assertion helpers shared by the rasterizer RTL.
`ifndef LINE_PIXEL_RASTERIZER_MACROS_SVH
`define LINE_PIXEL_RASTERIZER_MACROS_SVH

// Checked on every rising edge of clk, suspended while rst_n is low.
`define LPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define LPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/lpr_pkg.sv
package lpr_pkg;

  localparam int Z_W     = 9;
  localparam int COLOR_W = 24;

  // Color of a segment with equal end heights: FLAT_BASE - FLAT_SCALE * z_start.
  localparam logic [COLOR_W-1:0] COLOR_FLAT_BASE  = 24'hAFFFFF;
  localparam int                 COLOR_FLAT_SCALE = 67;
  // Color of a sloped segment: SLOPE_BASE - SLOPE_SCALE * z_start.
  localparam logic [COLOR_W-1:0] COLOR_SLOPE_BASE  = 24'h8FFFFF;
  localparam int                 COLOR_SLOPE_SCALE = 1241;
  localparam logic [COLOR_W-1:0] COLOR_BLACK       = 24'h000000;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } lpr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture a segment and set up the stepper
    logic emit;  // move the current pixel to the output register and step
  } lpr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;  // the current pixel is the final one of the segment
  } lpr_stat_t;

endpackage

FILE: rtl/core/lpr_seg_if.sv
interface lpr_seg_if #(
  parameter int unsigned COORD_WIDTH = 6
) ();
  logic                          valid;
  logic                          ready;
  logic [COORD_WIDTH-1:0]        x_start;
  logic [COORD_WIDTH-1:0]        y_start;
  logic [COORD_WIDTH-1:0]        x_end;
  logic [COORD_WIDTH-1:0]        y_end;
  logic signed [lpr_pkg::Z_W-1:0] z_start;
  logic signed [lpr_pkg::Z_W-1:0] z_end;

  modport source (
    output valid, x_start, y_start, x_end, y_end, z_start, z_end,
    input  ready
  );

  modport sink (
    input  valid, x_start, y_start, x_end, y_end, z_start, z_end,
    output ready
  );
endinterface

FILE: rtl/core/lpr_pix_if.sv
interface lpr_pix_if #(
  parameter int unsigned COORD_WIDTH = 6
) ();
  logic                          valid;
  logic                          ready;
  logic [COORD_WIDTH-1:0]        pixel_x;
  logic [COORD_WIDTH-1:0]        pixel_y;
  logic [lpr_pkg::COLOR_W-1:0]   pixel_color;
  logic                          last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
    output ready
  );
endinterface

FILE: rtl/core/lpr_ctrl.sv
`include "line_pixel_rasterizer_macros.svh"

module lpr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lpr_pkg::lpr_stat_t stat,
  output lpr_pkg::lpr_cmd_t  cmd
);

  lpr_pkg::lpr_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                slot_free;

  // The output register can take a pixel when empty or when drained this cycle.
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpr_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lpr_pkg::ST_EMIT;
      end
      lpr_pkg::ST_EMIT: begin
        if (slot_free && stat.last) state_nxt = lpr_pkg::ST_IDLE;
      end
      default: state_nxt = lpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      lpr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      lpr_pkg::ST_EMIT: begin
        cmd.emit = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = cmd.emit || (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `LPR_ASSERT(a_load_starts_emit, cmd.load |=> state_r == lpr_pkg::ST_EMIT, "segment accepted but no emit phase followed")
  `LPR_ASSERT(a_last_returns_idle, (cmd.emit && stat.last) |=> state_r == lpr_pkg::ST_IDLE, "final pixel sent but controller did not return to idle")
  `LPR_ASSERT(a_emit_fills_slot, cmd.emit |=> out_valid_r, "pixel emitted but output register not marked valid")
  `LPR_ASSERT_ALWAYS(a_no_load_while_emit, !(cmd.load && cmd.emit), "load and emit issued in the same cycle")

endmodule

FILE: rtl/core/lpr_datapath.sv
module lpr_datapath #(
  parameter int unsigned COORD_WIDTH = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  lpr_pkg::lpr_cmd_t              cmd,
  output lpr_pkg::lpr_stat_t             stat,
  input  logic [COORD_WIDTH-1:0]         x_start,
  input  logic [COORD_WIDTH-1:0]         y_start,
  input  logic [COORD_WIDTH-1:0]         x_end,
  input  logic [COORD_WIDTH-1:0]         y_end,
  input  logic signed [lpr_pkg::Z_W-1:0] z_start,
  input  logic signed [lpr_pkg::Z_W-1:0] z_end,
  output logic [COORD_WIDTH-1:0]         pixel_x,
  output logic [COORD_WIDTH-1:0]         pixel_y,
  output logic [lpr_pkg::COLOR_W-1:0]    pixel_color,
  output logic                           last_pixel
);

  localparam int CW  = COORD_WIDTH;
  localparam int AW  = COORD_WIDTH + 1;          // accumulator holds up to 2*major
  localparam int PW  = lpr_pkg::COLOR_W + 1;     // color product width

  logic color_enable_r;

  logic [CW-1:0] x_r, y_r, major_r, minor_r, steps_r;
  logic [AW-1:0] acc_r;
  logic          xmajor_r, xpos_r, ypos_r;
  logic [lpr_pkg::COLOR_W-1:0] color_r;

  logic [CW-1:0] pix_x_r, pix_y_r;
  logic [lpr_pkg::COLOR_W-1:0] pix_color_r;
  logic          pix_last_r;

  // Segment setup.
  logic [CW-1:0] adx, ady, major_s, minor_s;
  logic          xmajor_s;
  logic [PW-1:0] zs_ext, col_flat, col_slope;
  logic [lpr_pkg::COLOR_W-1:0] color_s;

  assign adx      = (x_end < x_start) ? (x_start - x_end) : (x_end - x_start);
  assign ady      = (y_end < y_start) ? (y_start - y_end) : (y_end - y_start);
  assign xmajor_s = adx > ady;
  assign major_s  = xmajor_s ? adx : ady;
  assign minor_s  = xmajor_s ? ady : adx;

  assign zs_ext    = PW'(z_start);
  assign col_flat  = PW'(lpr_pkg::COLOR_FLAT_BASE)
                   - zs_ext * PW'(lpr_pkg::COLOR_FLAT_SCALE);
  assign col_slope = PW'(lpr_pkg::COLOR_SLOPE_BASE)
                   - zs_ext * PW'(lpr_pkg::COLOR_SLOPE_SCALE);

  always_comb begin
    priority if (!color_enable_r) begin
      color_s = lpr_pkg::COLOR_BLACK;
    end else if (z_start == z_end) begin
      color_s = col_flat[lpr_pkg::COLOR_W-1:0];
    end else begin
      color_s = col_slope[lpr_pkg::COLOR_W-1:0];
    end
  end

  // One step of the error accumulator.
  logic [AW-1:0] acc_sum, acc_step;
  logic          minor_step;
  logic [CW-1:0] x_step, y_step;
  logic          move_x, move_y;

  assign acc_sum    = acc_r + AW'(minor_r);
  assign minor_step = acc_sum >= AW'(major_r);
  assign acc_step   = minor_step ? (acc_sum - AW'(major_r)) : acc_sum;
  assign move_x     = xmajor_r || minor_step;
  assign move_y     = !xmajor_r || minor_step;
  assign x_step     = xpos_r ? (x_r + CW'(1)) : (x_r - CW'(1));
  assign y_step     = ypos_r ? (y_r + CW'(1)) : (y_r - CW'(1));

  assign stat.last = (steps_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_enable_r <= 1'b1;
    end else if (cfg_wr_en) begin
      color_enable_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= '0;
    end else if (cmd.load) begin
      steps_r <= major_s;
    end else if (cmd.emit && !stat.last) begin
      steps_r <= steps_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r      <= x_start;
      y_r      <= y_start;
      major_r  <= major_s;
      minor_r  <= minor_s;
      xmajor_r <= xmajor_s;
      xpos_r   <= x_end > x_start;
      ypos_r   <= y_end > y_start;
      acc_r    <= AW'(major_s >> 1);
      color_r  <= color_s;
    end else if (cmd.emit) begin
      if (move_x) x_r <= x_step;
      if (move_y) y_r <= y_step;
      acc_r <= acc_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pix_x_r     <= x_r;
      pix_y_r     <= y_r;
      pix_color_r <= color_r;
      pix_last_r  <= stat.last;
    end
  end

  assign pixel_x     = pix_x_r;
  assign pixel_y     = pix_y_r;
  assign pixel_color = pix_color_r;
  assign last_pixel  = pix_last_r;

endmodule

FILE: rtl/core/line_pixel_rasterizer.sv
// Line pixel rasterizer. One input word describes a segment by its start and
// end pixel and a height at each end; the block answers with one output word
// per pixel of the segment, from the start point to the end point, with
// last_pixel set on the end point. Pixels are found with a Bresenham stepper:
// it walks the major axis (y when both deltas are equal), and an error
// accumulator that starts at half the major delta decides the minor steps.
// The whole segment gets one color, black when color_enable is 0, otherwise
// 0xAFFFFF - 67*z_start for equal end heights and 0x8FFFFF - 1241*z_start for
// unequal ones. Each segment is set up when it is accepted; then the stepper
// produces one pixel per cycle into a single output register and waits
// whenever that register is not drained. The next segment is accepted in
// the cycle after the last pixel has been moved into the output register,
// even while that pixel still waits there. The color_enable register is
// written through cfg_wr_en / cfg_wr_data; the user must write it only while
// the block is idle, which the block itself does not enforce, and it takes
// effect with the next segment.

module line_pixel_rasterizer #(
  parameter int unsigned COORD_WIDTH = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  lpr_seg_if.sink   in_seg,
  lpr_pix_if.source out_pix,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  // Command and status paths between the sequencer and the stepper.
  lpr_pkg::lpr_cmd_t  cmd;
  lpr_pkg::lpr_stat_t stat;

  // The controller owns the handshakes: it takes a segment only when idle and
  // fires one emit per cycle while the output register has room.
  lpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_seg.valid),
    .in_ready  (in_seg.ready),
    .out_valid (out_pix.valid),
    .out_ready (out_pix.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the configuration register, the segment setup, the
  // stepper and the output payload register.
  lpr_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .x_start     (in_seg.x_start),
    .y_start     (in_seg.y_start),
    .x_end       (in_seg.x_end),
    .y_end       (in_seg.y_end),
    .z_start     (in_seg.z_start),
    .z_end       (in_seg.z_end),
    .pixel_x     (out_pix.pixel_x),
    .pixel_y     (out_pix.pixel_y),
    .pixel_color (out_pix.pixel_color),
    .last_pixel  (out_pix.last_pixel)
  );

endmodule
